// ===== rtl/czfc_pkg.sv =====
// shared types and constants of the character zone feature counter
package czfc_pkg;

	// feature layout
	localparam int FEAT_NUM = 13;
	localparam int CNT_W = 13;
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] LAST_INDEX = 4'd12;
	localparam int F_TOTAL = 8;
	localparam int F_ROW_A = 9;
	localparam int F_ROW_B = 10;
	localparam int F_COL_A = 11;
	localparam int F_COL_B = 12;

	// configuration port
	localparam int CFG_W = 7;
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_BOX_HEIGHT = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_BOX_WIDTH = 1'b1;
	localparam int RESET_HEIGHT = 16;
	localparam int RESET_WIDTH = 8;

	// stream widths
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int PAD_W = OUT_TDATA_W - CNT_W - IDX_W;

	// queue between front and back
	localparam int QPTR_W = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_W;

	// x / 3 as (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2**17
	localparam int DIV3_MUL = 43691;
	localparam int DIV3_SHIFT = 17;

	typedef logic [CNT_W-1:0] count_t;

	// one classified pixel: which counters it bumps and whether it closes the box
	typedef struct packed {
		logic [FEAT_NUM-1:0] mask;
		logic                last;
	} item_t;

endpackage

// ===== rtl/czfc_front.sv =====
// front end: box geometry, pixel position tracking and feature classification
module czfc_front #(
	parameter int MAX_BOX_DIM = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [czfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [czfc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [czfc_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                            q_full,
	output logic                            push,
	output czfc_pkg::item_t                 push_item
);

	localparam int DIM_W = $clog2(MAX_BOX_DIM + 1);
	localparam int PW = $clog2(MAX_BOX_DIM);
	localparam int CW = (DIM_W > czfc_pkg::CFG_W) ? DIM_W : czfc_pkg::CFG_W;
	localparam int PROD_W = DIM_W + 1 + czfc_pkg::DIV3_SHIFT;
	localparam int RST_H = (czfc_pkg::RESET_HEIGHT > MAX_BOX_DIM) ?
		MAX_BOX_DIM : czfc_pkg::RESET_HEIGHT;
	localparam int RST_W = (czfc_pkg::RESET_WIDTH > MAX_BOX_DIM) ?
		MAX_BOX_DIM : czfc_pkg::RESET_WIDTH;

	logic [DIM_W-1:0] h_q, h4_q, h2_q, h34_q, h3_q, h23_q;
	logic [DIM_W-1:0] w_q, w2_q, w3_q, w23_q;
	logic [PW-1:0]    row_q, col_q;

	logic [CW-1:0]     wd_ext;
	logic [DIM_W-1:0]  cfg_dim;
	logic [DIM_W:0]    dim_x2;
	logic [DIM_W+1:0]  dim_x3;
	logic [PROD_W-1:0] prod1, prod2;
	logic [DIM_W-1:0]  dim_third, dim_two_third;

	logic [DIM_W-1:0] r_e, c_e;
	logic [3:0]       band;
	logic [1:0]       half;
	logic             last_col, last_row, black, accept;
	logic [czfc_pkg::FEAT_NUM-1:0] hits;

	// saturate the written dimension into 1..MAX_BOX_DIM
	always_comb begin
		wd_ext = CW'(cfg_wdata);
		if (cfg_wdata == '0) begin
			cfg_dim = DIM_W'(1);
		end else if (wd_ext > CW'(MAX_BOX_DIM)) begin
			cfg_dim = DIM_W'(MAX_BOX_DIM);
		end else begin
			cfg_dim = DIM_W'(wd_ext);
		end
	end

	// bounds derived from the new dimension, thirds by reciprocal multiply
	assign dim_x2 = {cfg_dim, 1'b0};
	assign dim_x3 = {1'b0, dim_x2} + (DIM_W + 2)'(cfg_dim);
	assign prod1 = PROD_W'(cfg_dim) * PROD_W'(czfc_pkg::DIV3_MUL);
	assign prod2 = PROD_W'(dim_x2) * PROD_W'(czfc_pkg::DIV3_MUL);
	assign dim_third = DIM_W'(prod1 >> czfc_pkg::DIV3_SHIFT);
	assign dim_two_third = DIM_W'(prod2 >> czfc_pkg::DIV3_SHIFT);

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= DIM_W'(RST_H);
			h4_q  <= DIM_W'(RST_H / 4);
			h2_q  <= DIM_W'(RST_H / 2);
			h34_q <= DIM_W'(3 * RST_H / 4);
			h3_q  <= DIM_W'(RST_H / 3);
			h23_q <= DIM_W'(2 * RST_H / 3);
			w_q   <= DIM_W'(RST_W);
			w2_q  <= DIM_W'(RST_W / 2);
			w3_q  <= DIM_W'(RST_W / 3);
			w23_q <= DIM_W'(2 * RST_W / 3);
		end else if (cfg_we) begin
			case (cfg_addr)
				czfc_pkg::REG_BOX_HEIGHT: begin
					h_q   <= cfg_dim;
					h4_q  <= cfg_dim >> 2;
					h2_q  <= cfg_dim >> 1;
					h34_q <= DIM_W'(dim_x3 >> 2);
					h3_q  <= dim_third;
					h23_q <= dim_two_third;
				end
				czfc_pkg::REG_BOX_WIDTH: begin
					w_q   <= cfg_dim;
					w2_q  <= cfg_dim >> 1;
					w3_q  <= dim_third;
					w23_q <= dim_two_third;
				end
				default: begin
				end
			endcase
		end
	end

	// classify the current pixel against the bounds
	always_comb begin
		r_e = DIM_W'(row_q);
		c_e = DIM_W'(col_q);
		band[0] = r_e < h4_q;
		band[1] = (r_e >= h4_q) && (r_e < h2_q);
		band[2] = (r_e >= h2_q) && (r_e < h34_q);
		band[3] = (r_e >= h34_q) && (r_e < h_q);
		half[0] = c_e < w2_q;
		half[1] = (c_e >= w2_q) && (c_e < w_q);
		last_col = (c_e + DIM_W'(1)) >= w_q;
		last_row = (r_e + DIM_W'(1)) >= h_q;
		black = !s_tdata[0];
		for (int a = 0; a < 8; a++) begin
			hits[a] = band[a / 2] && half[a % 2];
		end
		hits[czfc_pkg::F_TOTAL] = 1'b1;
		hits[czfc_pkg::F_ROW_A] = !last_col && (r_e == h3_q);
		hits[czfc_pkg::F_ROW_B] = !last_col && (r_e == h23_q);
		hits[czfc_pkg::F_COL_A] = !last_row && (c_e == w3_q);
		hits[czfc_pkg::F_COL_B] = !last_row && (c_e == w23_q);
	end

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign push = accept;
	assign push_item.mask = black ? hits : '0;
	assign push_item.last = last_row && last_col;

	// raster position within the box, restarted by any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (last_row) ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

endmodule

// ===== rtl/czfc_queue.sv =====
// short queue of classified pixels between front and back
module czfc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  czfc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            q_valid,
	output czfc_pkg::item_t q_item
);

	czfc_pkg::item_t                entry_q [czfc_pkg::QUEUE_DEPTH];
	logic [czfc_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [czfc_pkg::QPTR_W:0]      cnt_q;

	assign full = cnt_q == (czfc_pkg::QPTR_W + 1)'(czfc_pkg::QUEUE_DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_item = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + czfc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + czfc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + (czfc_pkg::QPTR_W + 1)'(1);
				2'b01: cnt_q <= cnt_q - (czfc_pkg::QPTR_W + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/czfc_back.sv =====
// back end: feature accumulators and the result buffer that streams the counts
module czfc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  logic                             q_valid,
	input  czfc_pkg::item_t                  q_item,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [czfc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast
);

	czfc_pkg::count_t               acc_q  [czfc_pkg::FEAT_NUM];
	czfc_pkg::count_t               snap_q [czfc_pkg::FEAT_NUM];
	logic                           busy_q;
	logic [czfc_pkg::IDX_W-1:0]     idx_q;
	logic                           out_acc, out_done, buf_free, take_box;

	assign out_acc = m_tvalid && m_tready;
	assign out_done = out_acc && (idx_q == czfc_pkg::LAST_INDEX);
	assign buf_free = !busy_q || out_done;
	assign pop = q_valid && (!q_item.last || buf_free);
	assign take_box = pop && q_item.last;

	// running counts of the box in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < czfc_pkg::FEAT_NUM; k++) begin
				acc_q[k] <= '0;
			end
		end else if (clear || take_box) begin
			for (int k = 0; k < czfc_pkg::FEAT_NUM; k++) begin
				acc_q[k] <= '0;
			end
		end else if (pop) begin
			for (int k = 0; k < czfc_pkg::FEAT_NUM; k++) begin
				acc_q[k] <= acc_q[k] + czfc_pkg::CNT_W'(q_item.mask[k]);
			end
		end
	end

	// result buffer: loaded at box end, shifts one feature per beat
	always_ff @(posedge clk) begin
		if (take_box) begin
			for (int k = 0; k < czfc_pkg::FEAT_NUM; k++) begin
				snap_q[k] <= acc_q[k] + czfc_pkg::CNT_W'(q_item.mask[k]);
			end
		end else if (out_acc) begin
			for (int k = 0; k < czfc_pkg::FEAT_NUM - 1; k++) begin
				snap_q[k] <= snap_q[k + 1];
			end
		end
	end

	// output sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (take_box) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (out_acc) begin
			if (out_done) begin
				busy_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + czfc_pkg::IDX_W'(1);
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata = {{czfc_pkg::PAD_W{1'b0}}, snap_q[0], idx_q};
	assign m_tlast = idx_q == czfc_pkg::LAST_INDEX;

endmodule

// ===== rtl/character_zone_feature_counter.sv =====
// Character zone feature counter. Binary pixels of one character box arrive in raster
// order, one beat per pixel (bit 0: 0 black and counted, 1 white); after the box's last
// pixel 13 result beats carry the black counts of the 4x2 zone grid (features 0-7), the
// box total (8), two row lines (9, 10) and two column lines (11, 12), the last beat with
// tlast. A pixel is taken every cycle while the queue has room; results leave one per
// cycle while m_tready is high, from a buffer that is loaded at box end, so the next box's
// pixels are counted while the finished box's results drain. A four-beat queue between
// classification and the accumulators absorbs output stalls before the input sees
// backpressure. Writing box_height (index 0) or box_width (index 1) restarts the box and
// drops a partial one; a value of 0 counts as 1 and one above MAX_BOX_DIM as MAX_BOX_DIM.
// Writes are for idle moments only.
module character_zone_feature_counter #(
	parameter int MAX_BOX_DIM = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [czfc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [czfc_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [czfc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] pixel_value, rest zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [czfc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [3:0] feature_index,
	                                                    // [16:4] feature_count, rest zero
	output logic                             m_tlast
);

	logic            push, q_full, pop, q_valid;
	czfc_pkg::item_t push_item, q_item;

	// classification
	czfc_front #(
		.MAX_BOX_DIM(MAX_BOX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	czfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// accumulation and result streaming
	czfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_we),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/czfc_checker.sv =====
// port-level checks of the character zone feature counter, bound to the top level
module czfc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [czfc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// tlast marks feature 12 only
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[3:0] == czfc_pkg::LAST_INDEX)))
		else $error("tlast does not match the last feature");

	// features of one box leave back to back in index order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))
		else $error("feature index did not step by one");

	// a new box starts at feature 0
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[3:0] == 4'd0)
		else $error("box results do not start at feature 0");

endmodule

bind character_zone_feature_counter czfc_checker u_czfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== sim/character_zone_feature_counter_test.sv =====
// self-checking testbench for the character zone feature counter
module character_zone_feature_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import czfc_pkg::*;

	localparam int MAX_DIM = 64;
	localparam int TOTAL_PIXELS = 240;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT = 2000;

	// one expected result beat
	typedef struct packed {
		logic [IDX_W-1:0] feat_idx;
		count_t           feat_cnt;
		logic             is_last;
	} feature_beat_t;

	// running feature counts of the current box and the results they produce
	class zone_feature_tracker;
		logic [CFG_W-1:0] height_reg;
		logic [CFG_W-1:0] width_reg;
		logic [5:0]       row_pos;
		logic [5:0]       col_pos;
		count_t           tally[FEAT_NUM];
		feature_beat_t    pending_features[$];
		int               errors;
		int               pixels;
		int               boxes;
		int               beats;

		function new();
			height_reg = CFG_W'(RESET_HEIGHT);
			width_reg = CFG_W'(RESET_WIDTH);
			errors = 0;
			pixels = 0;
			boxes = 0;
			beats = 0;
			clear_box();
		endfunction

		function void clear_box();
			row_pos = '0;
			col_pos = '0;
			foreach (tally[k]) tally[k] = '0;
		endfunction

		// zero counts as one, anything above the maximum as the maximum
		function int unsigned eff_dim(logic [CFG_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return 32'(v);
		endfunction

		function int unsigned box_pixels();
			return eff_dim(height_reg) * eff_dim(width_reg);
		endfunction

		function int pending();
			return pending_features.size();
		endfunction

		// a write restarts the box
		function void write_dim(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
			if (addr == REG_BOX_HEIGHT) height_reg = value;
			else width_reg = value;
			clear_box();
		endfunction

		function void take_pixel(logic px);
			int unsigned   h, w, r, c, k;
			int            band, half;
			bit            closes;
			feature_beat_t beat;
			h = eff_dim(height_reg);
			w = eff_dim(width_reg);
			r = row_pos;
			c = col_pos;
			pixels++;
			if (px == 1'b0) begin
				// zone grid; the last band and half reach the box edge, so every pixel has a zone
				band = -1;
				half = -1;
				for (k = 0; k < 4; k++)
					if (r >= k * h / 4 && r < (k + 1) * h / 4) band = k;
				for (k = 0; k < 2; k++)
					if (c >= k * w / 2 && c < (k + 1) * w / 2) half = k;
				if (band >= 0 && half >= 0) tally[band * 2 + half]++;
				tally[F_TOTAL]++;
				// row lines skip the last column, column lines the last row
				if (c + 1 < w) begin
					if (r == h / 3) tally[F_ROW_A]++;
					if (r == 2 * h / 3) tally[F_ROW_B]++;
				end
				if (r + 1 < h) begin
					if (c == w / 3) tally[F_COL_A]++;
					if (c == 2 * w / 3) tally[F_COL_B]++;
				end
			end
			closes = (r + 1 >= h) && (c + 1 >= w);
			if (c + 1 >= w) begin
				col_pos = '0;
				row_pos = 6'(r + 1);
			end else begin
				col_pos = 6'(c + 1);
			end
			if (closes) begin
				for (k = 0; k < FEAT_NUM; k++) begin
					beat.feat_idx = IDX_W'(k);
					beat.feat_cnt = tally[k];
					beat.is_last = (beat.feat_idx == LAST_INDEX);
					pending_features.push_back(beat);
				end
				boxes++;
				clear_box();
			end
		endfunction

		task flag_mismatch(string msg);
			errors++;
			if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task take_feature(logic [IDX_W-1:0] idx, count_t cnt, logic last);
			feature_beat_t want;
			beats++;
			if (pending_features.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat: index %0d count %0d last %0b",
					idx, cnt, last));
				return;
			end
			want = pending_features.pop_front();
			if (idx !== want.feat_idx)
				flag_mismatch($sformatf("feature index %0d, expected %0d", idx, want.feat_idx));
			if (cnt !== want.feat_cnt)
				flag_mismatch($sformatf("feature %0d count %0d, expected %0d",
					want.feat_idx, cnt, want.feat_cnt));
			if (last !== want.is_last)
				flag_mismatch($sformatf("feature %0d tlast %0b, expected %0b",
					want.feat_idx, last, want.is_last));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [0] pixel_value, rest zero
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [3:0] feature_index, [16:4] feature_count
	logic                   m_tlast;

	zone_feature_tracker tracker;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	bit hold_request = 1'b0;
	int holds_done = 0;
	int settings = 0;
	int quiet_cycles = 0;

	character_zone_feature_counter #(
		.MAX_BOX_DIM(MAX_DIM)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = recv_gaps ? $urandom_range(0, 6) : 0;
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				holds_done++;
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.take_feature(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: CNT_W], m_tlast);
			@(negedge clk);
		end
	end

	// one pixel beat, entered and left at a falling edge
	task automatic send_pixel(input logic px);
		int gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W-1){1'b0}}, px};
		do @(posedge clk); while (!s_tready);
		tracker.take_pixel(px);
		@(negedge clk);
	endtask

	task automatic send_box(input int black_pct);
		int n;
		n = tracker.box_pixels();
		repeat (n) send_pixel(($urandom_range(0, 99) < black_pct) ? 1'b0 : 1'b1);
	endtask

	task automatic set_box(input bit do_h, input logic [CFG_W-1:0] h,
			input bit do_w, input logic [CFG_W-1:0] w);
		if (do_h) begin
			cfg_we <= 1'b1;
			cfg_addr <= REG_BOX_HEIGHT;
			cfg_wdata <= h;
			@(posedge clk);
			tracker.write_dim(REG_BOX_HEIGHT, h);
			@(negedge clk);
		end
		if (do_w) begin
			cfg_we <= 1'b1;
			cfg_addr <= REG_BOX_WIDTH;
			cfg_wdata <= w;
			@(posedge clk);
			tracker.write_dim(REG_BOX_WIDTH, w);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// wait for every result, then let the pipeline settle
	task automatic wait_idle();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input bit do_h, input logic [CFG_W-1:0] h,
			input bit do_w, input logic [CFG_W-1:0] w, input int boxes, input int black_pct);
		send_gaps = ($urandom_range(0, 3) != 0);
		recv_gaps = ($urandom_range(0, 3) != 0);
		if (do_h || do_w) set_box(do_h, h, do_w, w);
		settings++;
		repeat (boxes) send_box(black_pct);
		s_tvalid <= 1'b0;
		wait_idle();
	endtask

	// stimulus
	initial begin
		int               sel, boxes;
		logic [CFG_W-1:0] h, w;
		bit               do_h, do_w;
		tracker = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset dimensions, then single-pixel boxes where both lines share row 0
		run_phase(1'b0, '0, 1'b0, '0, 1, 50);
		run_phase(1'b1, 7'd1, 1'b1, 7'd1, 1, 100);
		run_phase(1'b0, '0, 1'b0, '0, 1, 0);
		// zero is taken as one
		run_phase(1'b1, 7'd0, 1'b1, 7'd0, 3, 50);
		// oversized height clamps, a one-column box keeps its row lines at zero
		run_phase(1'b1, 7'd127, 1'b1, 7'd1, 1, 100);

		// a write mid-box drops the partial box
		run_phase(1'b1, 7'd2, 1'b1, 7'd3, 0, 0);
		repeat (3) send_pixel(1'b0);
		s_tvalid <= 1'b0;
		wait_idle();
		run_phase(1'b1, 7'd3, 1'b0, '0, 1, 100);

		// output held off while small boxes keep coming
		hold_request = 1'b1;
		run_phase(1'b1, 7'd2, 1'b1, 7'd2, 4, 50);

		// random dimensions and pixel densities
		while (tracker.pixels < TOTAL_PIXELS) begin
			sel = $urandom_range(0, 9);
			do_h = 1'b1;
			do_w = 1'b1;
			if (sel < 6) begin
				h = CFG_W'($urandom_range(1, 8));
				w = CFG_W'($urandom_range(1, 8));
				if (tracker.eff_dim(tracker.height_reg) <= 8
						&& tracker.eff_dim(tracker.width_reg) <= 8) begin
					case ($urandom_range(0, 4))
						0: do_w = 1'b0;
						1: do_h = 1'b0;
						default: ;
					endcase
				end
			end else if (sel < 8) begin
				h = CFG_W'($urandom_range(9, 24));
				w = CFG_W'($urandom_range(1, 2));
			end else begin
				h = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
				w = CFG_W'($urandom_range(0, 1));
			end
			if (sel >= 6 && $urandom_range(0, 1)) begin
				{h, w} = {w, h};
			end
			boxes = (tracker.eff_dim(do_h ? h : tracker.height_reg)
				* tracker.eff_dim(do_w ? w : tracker.width_reg) <= 20)
				? $urandom_range(1, 4) : 1;
			run_phase(do_h, h, do_w, w, boxes, $urandom_range(0, 4) * 25);
		end

		if (tracker.pending() != 0)
			tracker.flag_mismatch($sformatf("%0d result beats never arrived",
				tracker.pending()));

		$display("covered %0d pixels in %0d boxes over %0d box settings (clamped, 1-wide)",
			tracker.pixels, tracker.boxes, settings);
		$display("checked %0d result beats, %0d long output stalls, %0d mismatches",
			tracker.beats, holds_done, tracker.errors);
		if (tracker.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/czfc_pkg.sv
rtl/czfc_front.sv
rtl/czfc_queue.sv
rtl/czfc_back.sv
rtl/character_zone_feature_counter.sv
rtl/czfc_checker.sv
sim/character_zone_feature_counter_test.sv
